FILE: rtl/core/uet_pkg.sv
`timescale 1ns / 1ps

package uet_pkg;

  // operation codes carried in the low bits of in_tdata
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_SPARE  = 2'd3
  } uet_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } uet_state_t;

  // controls broadcast from the sequencer to every slot
  typedef struct packed {
    logic clr;    // clear hit flags at the start of a transaction
    logic scan;   // advance the hit chain one slot
    logic shift;  // slots at or above the hit take their upper neighbor
    logic load;   // slot at index count takes the key
  } uet_ctrl_t;

endpackage

FILE: rtl/core/uet_slot.sv
`timescale 1ns / 1ps

module uet_slot #(
  parameter int IDX = 0,
  parameter int VB  = 8,
  parameter int CW  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uet_pkg::uet_ctrl_t   ctrl,
  input  logic [CW-1:0]        cnt,
  input  logic [VB-1:0]        key_a,
  input  logic [VB-1:0]        key_b,
  input  logic                 hit_in,
  input  logic [2*VB-1:0]      nxt_entry,
  output logic                 hit_out,
  output logic [2*VB-1:0]      entry_out
);

  logic [2*VB-1:0] entry_r;
  logic            hit_r;
  logic            live;
  logic            match;
  logic [VB-1:0]   ea;
  logic [VB-1:0]   eb;

  assign ea    = entry_r[VB-1:0];
  assign eb    = entry_r[2*VB-1:VB];
  assign live  = CW'(IDX) < cnt;
  assign match = live && (((ea == key_a) && (eb == key_b)) ||
                          ((ea == key_b) && (eb == key_a)));

  // hit means a match exists at this slot or below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.clr) begin
      hit_r <= 1'b0;
    end else if (ctrl.scan) begin
      hit_r <= hit_in | match;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && (cnt == CW'(IDX))) begin
      entry_r <= {key_b, key_a};
    end else if (ctrl.shift && hit_r) begin
      entry_r <= nxt_entry;
    end
  end

  assign hit_out   = hit_r;
  assign entry_out = entry_r;

endmodule

FILE: rtl/core/undirected_edge_table.sv
`timescale 1ns / 1ps

// Table of undirected edges held in a row of EDGE_DEPTH slots, packed from slot 0
// up to the edge count. Each input transaction carries an operation (insert,
// remove, query) and a vertex pair; a pair matches a stored edge in either
// orientation. Every input transaction yields exactly one output transaction
// with found, table_full and the edge count after the operation. The key is
// latched at the accepting edge; the hit flag then ripples one slot per cycle
// up the slot chain through all EDGE_DEPTH slots, and the result is then
// committed into the output register. The next input transaction can be
// accepted in the cycle after the commit. The commit waits while the output
// register still holds a result that has not been taken. Remove closes the
// hole by shifting every slot above the match down by one. One transaction is
// in flight at a time; the next one is accepted as soon as the sequencer is
// idle, even while a result still waits in the output register. No clearing
// pass is needed after reset.

module undirected_edge_table #(
  parameter int EDGE_DEPTH  = 64,
  parameter int VERTEX_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // func[1:0], vertex_a, vertex_b, zero fill
  input  logic [((2+2*VERTEX_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // found, table_full, edge_count, zero fill
  output logic [((2+$clog2(EDGE_DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int VB     = VERTEX_BITS;
  localparam int CW     = $clog2(EDGE_DEPTH + 1);
  localparam int SW     = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int OUT_W  = ((2 + CW + 7) / 8) * 8;

  uet_pkg::uet_state_t state_r, state_nxt;
  uet_pkg::uet_ctrl_t  ctrl;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [1:0]        func_r;
  logic [VB-1:0]     key_a_r;
  logic [VB-1:0]     key_b_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              out_found_r;
  logic              out_full_r;
  logic [CW-1:0]     out_cnt_r;

  logic              in_hs;
  logic              commit;
  logic              found;
  logic              is_full;
  logic              do_ins;
  logic              do_rem;
  logic              refuse;

  // slot chain wiring
  logic [EDGE_DEPTH-1:0]   hit;
  logic [2*VB-1:0]         entry [EDGE_DEPTH];

  assign in_hs   = in_tvalid && in_tready;
  assign commit  = (state_r == uet_pkg::ST_UPDATE) && !(out_tvalid_r && !out_tready);
  assign found   = hit[EDGE_DEPTH-1];
  assign is_full = (cnt_r == CW'(EDGE_DEPTH));
  assign do_ins  = (uet_pkg::uet_func_t'(func_r) == uet_pkg::FUNC_INSERT) && !found && !is_full;
  assign refuse  = (uet_pkg::uet_func_t'(func_r) == uet_pkg::FUNC_INSERT) && !found && is_full;
  assign do_rem  = (uet_pkg::uet_func_t'(func_r) == uet_pkg::FUNC_REMOVE) && found;

  // row of slots; each hands its hit flag up and its entry down
  for (genvar i = 0; i < EDGE_DEPTH; i++) begin : g_slot
    logic            hit_prev;
    logic [2*VB-1:0] upper;
    if (i == 0) begin : g_first
      assign hit_prev = 1'b0;
    end else begin : g_mid
      assign hit_prev = hit[i-1];
    end
    if (i == EDGE_DEPTH - 1) begin : g_last
      // top slot keeps its own content; it falls outside the count after a remove
      assign upper = entry[i];
    end else begin : g_below
      assign upper = entry[i+1];
    end
    uet_slot #(
      .IDX (i),
      .VB  (VB),
      .CW  (CW)
    ) u_slot (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cnt       (cnt_r),
      .key_a     (key_a_r),
      .key_b     (key_b_r),
      .hit_in    (hit_prev),
      .nxt_entry (upper),
      .hit_out   (hit[i]),
      .entry_out (entry[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    unique case (state_r)
      uet_pkg::ST_IDLE: begin
        scan_nxt = '0;
        if (in_hs) state_nxt = uet_pkg::ST_SCAN;
      end
      uet_pkg::ST_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SW'(EDGE_DEPTH - 1)) state_nxt = uet_pkg::ST_UPDATE;
      end
      uet_pkg::ST_UPDATE: begin
        if (commit) state_nxt = uet_pkg::ST_IDLE;
      end
      default: state_nxt = uet_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    ctrl       = '0;
    unique case (state_r)
      uet_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // ready is high in idle, so an offer here is a transaction
        ctrl.clr  = in_tvalid;
      end
      uet_pkg::ST_SCAN: begin
        ctrl.scan = 1'b1;
      end
      uet_pkg::ST_UPDATE: begin
        ctrl.load  = commit && do_ins;
        ctrl.shift = commit && do_rem;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (commit && do_ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (commit && do_rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    if (commit) out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= uet_pkg::ST_IDLE;
      cnt_r        <= '0;
      scan_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      scan_r       <= scan_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // key latch for the transaction in flight
  always_ff @(posedge clk) begin
    if (in_hs) begin
      func_r  <= in_tdata[1:0];
      key_a_r <= in_tdata[2+VB-1:2];
      key_b_r <= in_tdata[2+2*VB-1:2+VB];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_found_r <= found;
      out_full_r  <= refuse;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_full_r, out_found_r});

`ifndef SYNTH
  // edge count never runs past the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(EDGE_DEPTH))
    else $error("edge count exceeds table depth");

  // an accepted transaction always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> (state_r == uet_pkg::ST_SCAN))
    else $error("accepted transaction did not enter scan");

  // the count only moves on a commit
  a_cnt_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(cnt_r))
    else $error("edge count changed outside a commit");

  // a refused insert never comes with a match
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_found_r && out_full_r))
    else $error("found and table_full both set");
`endif

endmodule
